>>> hdl/tcw_pkg.sv
// Package for the text console writer: widths, reset values, codes, states and control structs.
package tcw_pkg;

  // Fixed field widths
  localparam int COL_W   = 7;   // cursor / read column
  localparam int ROW_W   = 6;   // cursor / read row
  localparam int COLS_W  = 8;   // columns register
  localparam int ROWS_W  = 7;   // rows register
  localparam int ATTR_W  = 8;
  localparam int CHAR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int ADDR_W  = 13;  // linear cell index
  localparam int AREA_W  = 14;  // rows * columns, holds 8192
  localparam int IDX_W   = 2;   // configuration register index
  localparam int DATA_W  = 8;   // configuration write data

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;

  // Register reset values
  localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  localparam logic [COLS_W-1:0] COLS_MAX = 8'd128;
  localparam logic [ROWS_W-1:0] ROWS_MAX = 7'd64;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ADDR_W-1:0] LAST_ADDR    = 13'(DEPTH - 1);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [IDX_W-1:0] REG_ATTR    = 2'd2;

  // Action codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_ZERO,
    ST_FINISH
  } tcw_state_t;

  // Start point of the cell pointer for the scroll phases
  typedef enum logic {
    PTR_COLS,
    PTR_LASTROW
  } tcw_ptr_sel_t;

  typedef struct packed {
    logic         in_rdy;
    logic         exec;
    logic         ptr_load;
    tcw_ptr_sel_t ptr_sel;
    logic         copy_rd;
    logic         zero_wr;
    logic         load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic in_vld;
    logic is_read;
    logic need_scroll;
    logic rows_one;
    logic ptr_at_end;
    logic ptr_at_top;
    logic out_free;
  } tcw_stat_t;

endpackage

>>> hdl/tcw_intf.sv
// Channel interfaces of the text console writer: put/read items, results, register writes.
interface tcw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::ROW_W-1:0]  read_row;
  logic [tcw_pkg::COL_W-1:0]  read_col;

  modport source (output valid, action, char_code, read_row, read_col, input ready);
  modport sink   (input valid, action, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CELL_W-1:0] cell_value;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::ADDR_W-1:0] cursor_position;
  logic                       scrolled;

  modport source (output valid, cell_value, cursor_col, cursor_row, cursor_position, scrolled,
                  input ready);
  modport sink   (input valid, cell_value, cursor_col, cursor_row, cursor_position, scrolled,
                  output ready);
endinterface

interface tcw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::IDX_W-1:0]  reg_index;
  logic [tcw_pkg::DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> hdl/tcw_ctrl.sv
// Controller of the text console writer: sequences clearing, item execution, scroll and result.
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::tcw_stat_t st,
  output tcw_pkg::tcw_cmd_t  cmd,
  output tcw_pkg::tcw_state_t state
);

  tcw_pkg::tcw_state_t state_r, state_nxt;

  assign state = state_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        if (st.ptr_at_top) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (st.in_vld) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        if (!st.is_read && st.need_scroll) begin
          state_nxt = st.rows_one ? tcw_pkg::ST_ZERO : tcw_pkg::ST_COPY;
        end else if (st.out_free) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          state_nxt = tcw_pkg::ST_FINISH;
        end
      end
      tcw_pkg::ST_COPY: begin
        if (st.ptr_at_end) state_nxt = tcw_pkg::ST_DRAIN;
      end
      tcw_pkg::ST_DRAIN: begin
        state_nxt = tcw_pkg::ST_ZERO;
      end
      tcw_pkg::ST_ZERO: begin
        if (st.ptr_at_end) state_nxt = tcw_pkg::ST_FINISH;
      end
      tcw_pkg::ST_FINISH: begin
        if (st.out_free) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        cmd.zero_wr = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        cmd.in_rdy = 1'b1;
      end
      tcw_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!st.is_read && st.need_scroll) begin
          cmd.ptr_load = 1'b1;
          cmd.ptr_sel  = st.rows_one ? tcw_pkg::PTR_LASTROW : tcw_pkg::PTR_COLS;
        end else begin
          cmd.load_out = st.out_free;
        end
      end
      tcw_pkg::ST_COPY: begin
        cmd.copy_rd = 1'b1;
      end
      tcw_pkg::ST_DRAIN: begin
        cmd.ptr_load = 1'b1;
        cmd.ptr_sel  = tcw_pkg::PTR_LASTROW;
      end
      tcw_pkg::ST_ZERO: begin
        cmd.zero_wr = 1'b1;
      end
      tcw_pkg::ST_FINISH: begin
        cmd.load_out = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/tcw_datapath.sv
// Datapath of the text console writer: registers, cursor, cell store and result register.
module tcw_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_stat_t st,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch,
  tcw_cfg_if.sink           cfg_ch
);

  // Configuration registers
  logic [tcw_pkg::COLS_W-1:0] cols_r;
  logic [tcw_pkg::ROWS_W-1:0] rows_r;
  logic [tcw_pkg::ATTR_W-1:0] attr_r;
  logic [tcw_pkg::COLS_W-1:0] cols_nxt;
  logic [tcw_pkg::ROWS_W-1:0] rows_nxt;

  // Cursor
  logic [tcw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0] row_r, row_nxt;

  // Latched item
  logic                       act_r;
  logic [tcw_pkg::CHAR_W-1:0] ch_r;
  logic                       in_area_r;
  logic                       scroll_r;

  // Cell store and scroll pointer
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;
  logic [tcw_pkg::ADDR_W-1:0] ptr_r;
  logic [tcw_pkg::ADDR_W-1:0] cp_addr_r;
  logic                       cp_pend_r;

  // Result register
  logic                       out_valid_r;
  logic [tcw_pkg::CELL_W-1:0] out_cell_r;
  logic [tcw_pkg::COL_W-1:0]  out_col_r;
  logic [tcw_pkg::ROW_W-1:0]  out_row_r;
  logic [tcw_pkg::ADDR_W-1:0] out_pos_r;
  logic                       out_scr_r;

  logic                       take, cfg_wr, out_xfer, is_put, put_char;
  logic                       next_line, need_scroll;
  logic [tcw_pkg::COLS_W-1:0] col_p1;
  logic [tcw_pkg::ROWS_W-1:0] row_p1;
  logic [tcw_pkg::ROWS_W-1:0] rows_m1;
  logic [tcw_pkg::COLS_W-1:0] new_cols_m1;
  logic [tcw_pkg::ROWS_W-1:0] new_rows_m1;
  logic [tcw_pkg::AREA_W-1:0] area, area_m1, lastrow_base;
  logic [tcw_pkg::AREA_W-1:0] rd_lin, cur_lin, pos_lin;
  logic [tcw_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [tcw_pkg::CELL_W-1:0] wr_data;
  logic                       rd_en, wr_en;
  logic [tcw_pkg::CELL_W-1:0] cell_res;

  // Handshakes
  assign take     = cmd.in_rdy & in_ch.valid;
  assign cfg_wr   = cfg_ch.valid;
  assign out_xfer = out_valid_r & out_ch.ready;

  assign in_ch.ready  = cmd.in_rdy;
  assign cfg_ch.ready = 1'b1;

  // Clamped size from a register write
  always_comb begin
    cols_nxt = cfg_ch.wr_data;
    if (cfg_ch.wr_data == '0) cols_nxt = 8'd1;
    else if (cfg_ch.wr_data > tcw_pkg::COLS_MAX) cols_nxt = tcw_pkg::COLS_MAX;
    rows_nxt = cfg_ch.wr_data[tcw_pkg::ROWS_W-1:0];
    if (cfg_ch.wr_data[tcw_pkg::ROWS_W-1:0] == '0) rows_nxt = 7'd1;
    else if (cfg_ch.wr_data[tcw_pkg::ROWS_W-1:0] > tcw_pkg::ROWS_MAX) rows_nxt = tcw_pkg::ROWS_MAX;
  end

  assign new_cols_m1 = cols_nxt - 8'd1;
  assign new_rows_m1 = rows_nxt - 7'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= tcw_pkg::COLS_RESET;
      rows_r <= tcw_pkg::ROWS_RESET;
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr) begin
      case (cfg_ch.reg_index)
        tcw_pkg::REG_COLUMNS: cols_r <= cols_nxt;
        tcw_pkg::REG_ROWS:    rows_r <= rows_nxt;
        tcw_pkg::REG_ATTR:    attr_r <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // Cursor advance: wrap, newline and scroll decision
  assign is_put   = (act_r == tcw_pkg::ACT_PUT);
  assign put_char = is_put && (ch_r != tcw_pkg::NEWLINE_CODE);
  assign col_p1   = {1'b0, col_r} + 8'd1;
  assign row_p1   = {1'b0, row_r} + 7'd1;
  assign rows_m1  = rows_r - 7'd1;
  assign next_line   = is_put && ((ch_r == tcw_pkg::NEWLINE_CODE) || (col_p1 >= cols_r));
  assign need_scroll = next_line && (row_p1 >= rows_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      if (cfg_ch.reg_index == tcw_pkg::REG_COLUMNS && {1'b0, col_r} >= cols_nxt) begin
        col_nxt = new_cols_m1[tcw_pkg::COL_W-1:0];
      end
      if (cfg_ch.reg_index == tcw_pkg::REG_ROWS && {1'b0, row_r} >= rows_nxt) begin
        row_nxt = new_rows_m1[tcw_pkg::ROW_W-1:0];
      end
    end else if (cmd.exec && is_put) begin
      if (next_line) begin
        col_nxt = '0;
        row_nxt = need_scroll ? rows_m1[tcw_pkg::ROW_W-1:0] : row_p1[tcw_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_p1[tcw_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Item latch and scroll flag
  always_ff @(posedge clk) begin
    if (take) begin
      act_r     <= in_ch.action;
      ch_r      <= in_ch.char_code;
      in_area_r <= ({1'b0, in_ch.read_row} < rows_r) && ({1'b0, in_ch.read_col} < cols_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r <= 1'b0;
    end else if (take) begin
      scroll_r <= 1'b0;
    end else if (cmd.exec && need_scroll) begin
      scroll_r <= 1'b1;
    end
  end

  // Linear indexes
  assign area         = {7'd0, rows_r} * {6'd0, cols_r};
  assign area_m1      = area - 14'd1;
  assign lastrow_base = area - {6'd0, cols_r};
  assign rd_lin  = ({8'd0, in_ch.read_row} * {6'd0, cols_r}) + {7'd0, in_ch.read_col};
  assign cur_lin = ({8'd0, row_r} * {6'd0, cols_r}) + {7'd0, col_r};
  assign pos_lin = ({8'd0, row_nxt} * {6'd0, cols_r}) + {7'd0, col_nxt};

  // Scroll / clearing pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_load) begin
      ptr_r <= (cmd.ptr_sel == tcw_pkg::PTR_COLS) ? {5'd0, cols_r}
                                                   : lastrow_base[tcw_pkg::ADDR_W-1:0];
    end else if (cmd.copy_rd || cmd.zero_wr) begin
      ptr_r <= ptr_r + 13'd1;
    end
  end

  // Pending copy write, one row above the cell just read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_pend_r <= 1'b0;
    end else begin
      cp_pend_r <= cmd.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) cp_addr_r <= ptr_r - {5'd0, cols_r};
  end

  // Cell store ports
  assign rd_en   = take | cmd.copy_rd;
  assign rd_addr = take ? rd_lin[tcw_pkg::ADDR_W-1:0] : ptr_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    if (cmd.zero_wr) begin
      wr_en = 1'b1;
    end else if (cp_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_addr_r;
      wr_data = rd_data_r;
    end else if (cmd.exec && put_char) begin
      wr_en   = 1'b1;
      wr_addr = cur_lin[tcw_pkg::ADDR_W-1:0];
      wr_data = {attr_r, ch_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Result register
  assign cell_res = (!is_put && in_area_r) ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cell_r <= cell_res;
      out_col_r  <= col_nxt;
      out_row_r  <= row_nxt;
      out_pos_r  <= pos_lin[tcw_pkg::ADDR_W-1:0];
      out_scr_r  <= scroll_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cell_value      = out_cell_r;
  assign out_ch.cursor_col      = out_col_r;
  assign out_ch.cursor_row      = out_row_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.scrolled        = out_scr_r;

  // Status to the controller
  assign st.in_vld      = in_ch.valid;
  assign st.is_read     = !is_put;
  assign st.need_scroll = need_scroll;
  assign st.rows_one    = (rows_r == 7'd1);
  assign st.ptr_at_end  = ({1'b0, ptr_r} == area_m1);
  assign st.ptr_at_top  = (ptr_r == tcw_pkg::LAST_ADDR);
  assign st.out_free    = !out_valid_r || out_ch.ready;

endmodule

>>> hdl/text_console_writer_core.sv
// Top level of the text console writer: controller, datapath and checks.
// Put or read without scroll: EXEC loads the result register if it is free, else
//   FINISH does; the cell store has one read and one write port.
// A new item is taken only in IDLE. Scroll copies the rows up in COPY, then DRAIN
//   (when rows > 1), clears the bottom row in ZERO and loads the result in FINISH.
// Reset: synchronous, active low; then a clearing pass over all 8192 cells of the
//   cell store with input ready low (register writes are taken throughout).
module text_console_writer_core (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  tcw_cfg_if.sink    cfg_ch
);

  tcw_pkg::tcw_cmd_t   cmd;
  tcw_pkg::tcw_stat_t  st;
  tcw_pkg::tcw_state_t state;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd),
    .state (state)
  );

  tcw_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .st     (st),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // One item at a time: ready drops after an input transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // The result register is loaded only when it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result overwritten before transfer");

  // No cell copy or clear while the input is ready
  a_no_mem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(cmd.copy_rd || cmd.zero_wr))
    else $error("cell store busy while input ready");

  // A fresh result only follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state != tcw_pkg::ST_IDLE && state != tcw_pkg::ST_CLEAR))
    else $error("result appeared without an item in work");

endmodule

>>> test/console_checker.sv
// Checker for the text console writer: mirrors the console state and compares every result.
module console_checker
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcw_in_if    in_ch,
  tcw_out_if   out_ch,
  tcw_cfg_if   cfg_ch,
  output int   fault_count,
  output int   results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_position;
    logic              scrolled;
  } console_result_t;

  // Mirror of the console: cell store, cursor and area registers
  logic [CELL_W-1:0] screen [DEPTH];
  int unsigned       area_w;
  int unsigned       area_h;
  int unsigned       cur_x;
  int unsigned       cur_y;
  logic [ATTR_W-1:0] attr_byte;

  console_result_t   due_results [$];
  console_result_t   oldest;
  int                faults;

  // Move rows up by one and blank the bottom row
  function automatic void scroll_screen();
    for (int r = 1; r < area_h; r++)
      for (int c = 0; c < area_w; c++)
        screen[(r - 1) * area_w + c] = screen[r * area_w + c];
    for (int c = 0; c < area_w; c++)
      screen[(area_h - 1) * area_w + c] = '0;
    cur_y = area_h - 1;
  endfunction

  // Carriage return plus line feed; returns 1 when the screen had to scroll
  function automatic logic line_feed();
    cur_x = 0;
    cur_y++;
    if (cur_y >= area_h) begin
      scroll_screen();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Register write, sizes clamped, cursor pulled inside a shrunk area
  function automatic void apply_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_COLUMNS: begin
        area_w = (data == 0) ? 1 : (data > MAX_COLUMNS) ? MAX_COLUMNS : data;
        if (cur_x >= area_w) cur_x = area_w - 1;
      end
      REG_ROWS: begin
        area_h = (data[6:0] == 0) ? 1 : (data[6:0] > MAX_ROWS) ? MAX_ROWS : data[6:0];
        if (cur_y >= area_h) cur_y = area_h - 1;
      end
      REG_ATTR: attr_byte = data;
      default: ;
    endcase
  endfunction

  // Expected result of one put or read transfer, updating the mirror
  function automatic console_result_t console_step(logic action, logic [CHAR_W-1:0] code,
                                                   logic [ROW_W-1:0] rrow,
                                                   logic [COL_W-1:0] rcol);
    console_result_t res;
    res = '0;
    if (action == ACT_READ) begin
      if (rrow < area_h && rcol < area_w) res.cell_value = screen[rrow * area_w + rcol];
    end else if (code == NEWLINE_CODE) begin
      res.scrolled = line_feed();
    end else begin
      screen[cur_y * area_w + cur_x] = {attr_byte, code};
      cur_x++;
      if (cur_x >= area_w) res.scrolled = line_feed();
    end
    res.cursor_col      = COL_W'(cur_x);
    res.cursor_row      = ROW_W'(cur_y);
    res.cursor_position = ADDR_W'(cur_y * area_w + cur_x);
    return res;
  endfunction

  function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) screen[i] = '0;
      area_w    = COLS_RESET;
      area_h    = ROWS_RESET;
      attr_byte = ATTR_RESET;
      cur_x     = 0;
      cur_y     = 0;
      faults    = 0;
      due_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.reg_index, cfg_ch.wr_data);
      // results first, so a result in the same cycle cannot match an item just taken
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with none expected: cell %0d, col %0d, row %0d",
                   $time, out_ch.cell_value, out_ch.cursor_col, out_ch.cursor_row);
          faults++;
        end else begin
          oldest = due_results.pop_front();
          compare_field("cell_value", oldest.cell_value, out_ch.cell_value);
          compare_field("cursor_col", oldest.cursor_col, out_ch.cursor_col);
          compare_field("cursor_row", oldest.cursor_row, out_ch.cursor_row);
          compare_field("cursor_position", oldest.cursor_position, out_ch.cursor_position);
          compare_field("scrolled", oldest.scrolled, out_ch.scrolled);
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(console_step(in_ch.action, in_ch.char_code,
                                           in_ch.read_row, in_ch.read_col));
    end
    fault_count <= faults;
    results_due <= due_results.size();
  end

endmodule

>>> test/text_console_writer_core_test.sv
// Testbench top for the text console writer: clock, reset, stimulus, watchdog and verdict.
module text_console_writer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int                ITEMS          = 1600;
  localparam int                HOLD_CYCLES    = 400;
  localparam int                WATCHDOG_LIMIT = 40000;
  localparam int                TAIL_CYCLES    = 20;
  localparam logic [IDX_W-1:0]  REG_SPARE      = 2'd3;

  logic clk;
  logic rst_n;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();
  tcw_cfg_if cfg_ch();

  int fault_count;
  int results_due;
  int items_sent;
  int area_cols;
  int area_rows;
  bit steady;
  bit hold_results;

  text_console_writer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  console_checker console_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fault_count (fault_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("text_console_writer_core_test: FAIL");
    $finish;
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // All registers, plus a write to the unused index which must be ignored
  task automatic set_area(logic [DATA_W-1:0] cols, logic [DATA_W-1:0] rows,
                          logic [DATA_W-1:0] attr);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_ATTR, attr);
    write_reg(REG_SPARE, DATA_W'($urandom_range(255)));
    cfg_ch.valid <= 1'b0;
    area_cols = (cols == 0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
    area_rows = (rows[6:0] == 0) ? 1 : (rows[6:0] > MAX_ROWS) ? MAX_ROWS : rows[6:0];
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic send_item(logic action, logic [CHAR_W-1:0] code, logic [ROW_W-1:0] row,
                           logic [COL_W-1:0] col);
    if (!steady && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= action;
    in_ch.char_code <= code;
    in_ch.read_row  <= row;
    in_ch.read_col  <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Random mix of reads (mostly inside the area), newlines and arbitrary bytes
  task automatic run_phase(int count, int newline_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        if ($urandom_range(3) != 0)
          send_item(ACT_READ, CHAR_W'($urandom_range(255)),
                    ROW_W'($urandom_range(area_rows - 1)),
                    COL_W'($urandom_range(area_cols - 1)));
        else
          send_item(ACT_READ, CHAR_W'($urandom_range(255)), ROW_W'($urandom_range(63)),
                    COL_W'($urandom_range(127)));
      end else if (roll < 30 + newline_pct) begin
        send_item(ACT_PUT, NEWLINE_CODE, ROW_W'($urandom_range(63)),
                  COL_W'($urandom_range(127)));
      end else begin
        send_item(ACT_PUT, CHAR_W'($urandom_range(255)), ROW_W'($urandom_range(63)),
                  COL_W'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_PUT;
    in_ch.char_code  <= '0;
    in_ch.read_row   <= '0;
    in_ch.read_col   <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_COLUMNS;
    cfg_ch.wr_data   <= '0;
    rst_n            <= 1'b0;
    items_sent   = 0;
    steady       = 1'b0;
    hold_results = 1'b0;
    area_cols    = COLS_RESET;
    area_rows    = ROWS_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset area: cleared store, bytes with the top bit set, reads outside the area
    send_item(ACT_READ, 8'h00, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h41, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'hFF, 6'd63, 7'd127);
    send_item(ACT_PUT, 8'h00, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h80, 6'd0, 7'd0);
    send_item(ACT_PUT, NEWLINE_CODE, 6'd0, 7'd0);
    send_item(ACT_READ, 8'hFF, 6'd0, 7'd1);
    send_item(ACT_READ, 8'h00, 6'd0, 7'd3);
    send_item(ACT_READ, 8'h00, 6'd25, 7'd0);
    send_item(ACT_READ, 8'h00, 6'd0, 7'd80);
    send_item(ACT_READ, 8'h00, 6'd63, 7'd127);

    // Zero sizes become a single cell; cursor row pulled back; single-row scrolls
    drain_results();
    set_area(8'd0, 8'h80, 8'hFF);
    send_item(ACT_PUT, 8'h5A, 6'd0, 7'd0);
    send_item(ACT_READ, 8'h00, 6'd0, 7'd0);
    send_item(ACT_PUT, NEWLINE_CODE, 6'd0, 7'd0);

    // Oversized values clamp to the maximum area
    drain_results();
    set_area(8'hFF, 8'h7F, 8'h00);
    send_item(ACT_PUT, 8'h61, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h62, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h63, 6'd0, 7'd0);
    send_item(ACT_PUT, NEWLINE_CODE, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h64, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h65, 6'd0, 7'd0);
    send_item(ACT_PUT, 8'h66, 6'd0, 7'd0);

    // Columns shrunk under the cursor, then a wrap that scrolls
    drain_results();
    set_area(8'd2, 8'd2, 8'h3C);
    send_item(ACT_PUT, 8'h7E, 6'd0, 7'd0);
    send_item(ACT_READ, 8'h00, 6'd0, 7'd1);
    send_item(ACT_READ, 8'h00, 6'd1, 7'd1);
    send_item(ACT_READ, 8'h00, 6'd0, 7'd0);

    // Full area, newline heavy so that a few full-size scrolls happen
    drain_results();
    set_area(8'd128, 8'd64, DATA_W'($urandom_range(255)));
    run_phase(140, 55);

    // No idling on either side
    drain_results();
    set_area(DATA_W'($urandom_range(1, 12)), DATA_W'($urandom_range(1, 6)),
             DATA_W'($urandom_range(255)));
    steady = 1'b1;
    run_phase(150, 10);

    // Result side held off while items keep coming, so the input backs up
    drain_results();
    set_area(DATA_W'($urandom_range(1, 12)), DATA_W'($urandom_range(1, 6)),
             DATA_W'($urandom_range(255)));
    hold_results = 1'b1;
    run_phase(60, 10);
    steady = 1'b0;

    // Random settings, mostly small areas so that scrolls stay short
    while (items_sent < ITEMS) begin
      drain_results();
      case ($urandom_range(7))
        0: set_area(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(1, 3)),
                    DATA_W'($urandom_range(255)));
        1: set_area(DATA_W'($urandom_range(1, 6)), DATA_W'($urandom_range(255)),
                    DATA_W'($urandom_range(255)));
        default: set_area(DATA_W'($urandom_range(1, 12)), DATA_W'($urandom_range(1, 6)),
                          DATA_W'($urandom_range(255)));
      endcase
      run_phase($urandom_range(40, 100), $urandom_range(3, 20));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && results_due == 0)
      $display("text_console_writer_core_test: PASS");
    else
      $display("text_console_writer_core_test: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/tcw_pkg.sv
hdl/tcw_intf.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer_core.sv
test/console_checker.sv
test/text_console_writer_core_test.sv
